// ===== src/lithium_cell_charge_controller_top_macros.svh =====
// Assertion macros shared by the charge controller RTL.
// Needs nothing; files that assert include it by name.
`ifndef LITHIUM_CELL_CHARGE_CONTROLLER_TOP_MACROS_SVH
`define LITHIUM_CELL_CHARGE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define LCCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lccc_pkg.sv =====
// Types, constants and helper functions for the charge controller.
// No dependencies; used by every other RTL file.
`default_nettype none

package lccc_pkg;

   localparam int CELLS_DEF   = 6;
   localparam int INPUT_CELLS = 6;

   localparam logic [13:0] MAX_CURRENT_MA = 14'd10000;
   localparam logic [9:0]  OC_MARGIN_MA   = 10'd500;

   // start values that follow from the reset register contents
   localparam logic [12:0] RST_TARGET_MV = 13'd4200;
   localparam logic [9:0]  RST_BHYST_MV  = 10'd10;
   localparam logic [9:0]  RST_CHYST_MA  = 10'd50;
   localparam logic [15:0] RST_STABLE    = 16'd3000;
   localparam logic [13:0] RST_LIMIT     = 14'd50;
   localparam logic [10:0] RST_DIV10     = 11'd5;
   localparam logic [11:0] RST_DIV5      = 12'd10;

   typedef enum logic [2:0] {
      CSR_CHEM_TYPE    = 3'd0,
      CSR_CHARGE_MODE  = 3'd1,
      CSR_SET_CURRENT  = 3'd2,
      CSR_CELL_COUNT   = 3'd3,
      CSR_TARGET       = 3'd4,
      CSR_BALANCE_HYST = 3'd5,
      CSR_CURRENT_HYST = 3'd6,
      CSR_STABLE_TICKS = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_PRE  = 2'd0,
      PH_CCCV = 2'd1,
      PH_BAL  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   localparam logic [1:0] MODE_BALANCE = 2'd0;
   localparam logic [1:0] MODE_FAST    = 2'd2;
   localparam logic [1:0] MODE_STORAGE = 2'd3;

   localparam logic [1:0] DRV_HOLD = 2'd0;
   localparam logic [1:0] DRV_UP   = 2'd1;
   localparam logic [1:0] DRV_DOWN = 2'd2;

   typedef struct packed {
      logic [12:0] target_mv;
      logic [13:0] limit_ma;
      logic [10:0] limit_div10;
      logic [11:0] limit_div5;
   } start_type;

   typedef struct packed {
      logic [1:0]  chem_type;
      logic [1:0]  charge_mode;
      logic [2:0]  cell_count;
      logic [9:0]  balance_hyst_mv;
      logic [9:0]  current_hyst_ma;
      logic [15:0] stable_ticks;
      start_type   start;
   } cfg_type;

   typedef struct packed {
      logic        start_req;
      logic [15:0] charge_current_ma;
      logic [15:0] cell1_mv;
      logic [15:0] cell2_mv;
      logic [15:0] cell3_mv;
      logic [15:0] cell4_mv;
      logic [15:0] cell5_mv;
      logic [15:0] cell6_mv;
   } req_type;

   typedef struct packed {
      logic [1:0] drive_cmd;
      logic       overcurrent_trip;
      logic       charger_off;
      logic [5:0] balance_mask;
      logic [1:0] phase;
      logic       cooling_on;
   } rsp_type;

   // precharge threshold per chemistry
   function automatic logic [11:0] precharge_mv(input logic [1:0] chem);
      logic [11:0] v;
      case (chem)
         2'd0:    v = 12'd3200;
         2'd3:    v = 12'd3300;
         default: v = 12'd2500;
      endcase
      return v;
   endfunction

   // x / 11 via reciprocal, exact for 13-bit x
   function automatic logic [9:0] div11(input logic [12:0] x);
      logic [29:0] p;
      p = x * 17'd95326;
      return p[29:20];
   endfunction

   // x / 10 via reciprocal, exact for 14-bit x
   function automatic logic [10:0] div10(input logic [13:0] x);
      logic [30:0] p;
      p = x * 17'd104858;
      return p[30:20];
   endfunction

   // x / 5 via reciprocal, exact for 14-bit x
   function automatic logic [11:0] div5(input logic [13:0] x);
      logic [31:0] p;
      p = x * 18'd209716;
      return p[31:20];
   endfunction

endpackage

`default_nettype wire

// ===== src/lccc_if.sv =====
// Valid/ready channel interfaces for the charge controller.
// Depends on lccc_pkg for the payload types.
`default_nettype none

interface lccc_req_if
   import lccc_pkg::*;
   ;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lccc_rsp_if
   import lccc_pkg::*;
   ;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/lccc_csr.sv =====
// Configuration register file plus registered start values (target, limit,
// limit/10, limit/5). Depends on lccc_pkg.
`default_nettype none

module lccc_csr
   import lccc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_idx,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   logic [1:0]  chem_ff, mode_ff;
   logic [13:0] set_cur_ff;
   logic [2:0]  count_ff;
   logic [12:0] target_ff;
   logic [9:0]  bhyst_ff, chyst_ff;
   logic [15:0] stable_ff;
   start_type   start_ff, start_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         chem_ff    <= '0;
         mode_ff    <= '0;
         set_cur_ff <= '0;
         count_ff   <= '0;
         target_ff  <= RST_TARGET_MV;
         bhyst_ff   <= RST_BHYST_MV;
         chyst_ff   <= RST_CHYST_MA;
         stable_ff  <= RST_STABLE;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_CHEM_TYPE:    chem_ff    <= csr_wdata[1:0];
            CSR_CHARGE_MODE:  mode_ff    <= csr_wdata[1:0];
            CSR_SET_CURRENT:  set_cur_ff <= csr_wdata[13:0];
            CSR_CELL_COUNT:   count_ff   <= csr_wdata[2:0];
            CSR_TARGET:       target_ff  <= csr_wdata[12:0];
            CSR_BALANCE_HYST: bhyst_ff   <= csr_wdata[9:0];
            CSR_CURRENT_HYST: chyst_ff   <= csr_wdata[9:0];
            CSR_STABLE_TICKS: stable_ff  <= csr_wdata;
         endcase
      end
   end

   // values latched by a start, recomputed every cycle
   always_comb begin
      logic [13:0] lim;
      lim = (set_cur_ff > MAX_CURRENT_MA) ? MAX_CURRENT_MA : set_cur_ff;
      if (lim < {4'b0, chyst_ff}) begin
         lim = {4'b0, chyst_ff};
      end
      start_in.limit_ma    = lim;
      start_in.limit_div10 = div10(lim);
      start_in.limit_div5  = div5(lim);
      if (mode_ff == MODE_STORAGE) begin
         start_in.target_mv = target_ff - {3'b0, div11(target_ff)};
      end else begin
         start_in.target_mv = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff.target_mv   <= RST_TARGET_MV;
         start_ff.limit_ma    <= RST_LIMIT;
         start_ff.limit_div10 <= RST_DIV10;
         start_ff.limit_div5  <= RST_DIV5;
      end else begin
         start_ff <= start_in;
      end
   end

   assign cfg.chem_type       = chem_ff;
   assign cfg.charge_mode     = mode_ff;
   assign cfg.cell_count      = count_ff;
   assign cfg.balance_hyst_mv = bhyst_ff;
   assign cfg.current_hyst_ma = chyst_ff;
   assign cfg.stable_ticks    = stable_ff;
   assign cfg.start           = start_ff;

endmodule

`default_nettype wire

// ===== src/lccc_core.sv =====
// Input register, per-tick charge control logic, charge state and result
// register. Depends on lccc_pkg, lccc_if and the assertion macro header.
`default_nettype none
`include "lithium_cell_charge_controller_top_macros.svh"

module lccc_core
   import lccc_pkg::*;
#(
   parameter int CELLS = CELLS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   lccc_req_if.sink    req,
   lccc_rsp_if.source  rsp
);

   localparam logic [2:0] CELLS_N = 3'(CELLS);

   // pipeline registers
   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;
   logic    out_rdy, step, accept;

   // charge state
   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [12:0] target_ff, target_in;
   logic [13:0] limit_ff, limit_in;
   logic [10:0] div10_ff, div10_in;
   logic [11:0] div5_ff, div5_in;
   logic [5:0]  bleed_ff, bleed_in;
   logic        fan_ff, fan_in;

   assign out_rdy   = !out_vld_ff || rsp.ready;
   assign step      = in_vld_ff && out_rdy;
   assign req.ready = !in_vld_ff || out_rdy;
   assign accept    = req.valid && req.ready;

   assign in_vld_in  = accept ? 1'b1 : (step ? 1'b0 : in_vld_ff);
   assign out_vld_in = step ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);

   // ---- tick evaluation ----
   logic [15:0] cell_mv [INPUT_CELLS];
   logic [15:0] cur, vmin, vmax;
   logic [2:0]  n_cells;
   phase_type   ph;
   logic [15:0] cnt0;
   logic        start;
   logic [12:0] lo_mv;
   logic [13:0] lim_lo, vlim;
   logic [10:0] pre, pre_lo;
   logic [11:0] endc;
   logic        below_pre;

   assign start = in_ff.start_req;
   assign cur   = in_ff.charge_current_ma;
   assign cell_mv[0] = in_ff.cell1_mv;
   assign cell_mv[1] = in_ff.cell2_mv;
   assign cell_mv[2] = in_ff.cell3_mv;
   assign cell_mv[3] = in_ff.cell4_mv;
   assign cell_mv[4] = in_ff.cell5_mv;
   assign cell_mv[5] = in_ff.cell6_mv;

   // a start latches first, then the same tick runs control
   assign target_in = start ? cfg.start.target_mv   : target_ff;
   assign limit_in  = start ? cfg.start.limit_ma    : limit_ff;
   assign div10_in  = start ? cfg.start.limit_div10 : div10_ff;
   assign div5_in   = start ? cfg.start.limit_div5  : div5_ff;
   assign ph        = start ? PH_PRE : phase_ff;
   assign cnt0      = start ? 16'd0 : count_ff;

   assign n_cells = (cfg.cell_count > CELLS_N) ? CELLS_N : cfg.cell_count;

   always_comb begin
      vmin = 16'hFFFF;
      vmax = 16'd0;
      for (int i = 0; i < INPUT_CELLS; i++) begin
         if (3'(i) < n_cells) begin
            if (cell_mv[i] > vmax) vmax = cell_mv[i];
            if (cell_mv[i] < vmin) vmin = cell_mv[i];
         end
      end
   end

   assign lo_mv  = (target_in > {3'b0, cfg.balance_hyst_mv}) ?
                   target_in - {3'b0, cfg.balance_hyst_mv} : 13'd0;
   assign lim_lo = (limit_in > {4'b0, cfg.current_hyst_ma}) ?
                   limit_in - {4'b0, cfg.current_hyst_ma} : 14'd0;
   assign pre    = (div10_in < {1'b0, cfg.current_hyst_ma}) ?
                   {1'b0, cfg.current_hyst_ma} : div10_in;
   assign pre_lo = (pre > {1'b0, cfg.current_hyst_ma}) ?
                   pre - {1'b0, cfg.current_hyst_ma} : 11'd0;
   assign endc   = (cfg.charge_mode == MODE_FAST) ? div5_in : {1'b0, div10_in};
   assign vlim   = (ph == PH_BAL) ? {1'b0, target_in} + {4'b0, cfg.balance_hyst_mv}
                                  : {1'b0, target_in};
   assign below_pre = vmin < {4'b0, precharge_mv(cfg.chem_type)};

   // next phase
   always_comb begin
      phase_in = ph;
      unique case (ph)
         PH_PRE: begin
            if (!below_pre) phase_in = PH_CCCV;
         end
         PH_CCCV: begin
            if (cur < {4'b0, endc} && cnt0 == cfg.stable_ticks) phase_in = PH_BAL;
         end
         PH_BAL: begin
            if (cfg.charge_mode != MODE_BALANCE || vmin > {3'b0, lo_mv}) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: phase_in = PH_DONE;
      endcase
   end

   // drive command, counter, bleeds, fan
   always_comb begin
      logic up, down, off;
      up       = 1'b0;
      down     = (cur > {2'b0, limit_in}) || (vmax > {2'b0, vlim});
      off      = 1'b0;
      count_in = cnt0;
      bleed_in = bleed_ff;
      fan_in   = start | fan_ff;
      unique case (ph)
         PH_PRE: begin
            if (below_pre) begin
               if (cur > {5'b0, pre}) down = 1'b1;
               else if (cur < {5'b0, pre_lo}) up = 1'b1;
            end
         end
         PH_CCCV: begin
            if (vmin < {3'b0, lo_mv} || cur < {2'b0, lim_lo}) up = 1'b1;
            if (cur < {4'b0, endc}) begin
               if (cnt0 != cfg.stable_ticks) count_in = cnt0 + 16'd1;
            end else begin
               count_in = 16'd0;
            end
         end
         PH_BAL: begin
            if (cfg.charge_mode == MODE_BALANCE && !(vmin > {3'b0, lo_mv})) begin
               for (int i = 0; i < CELLS; i++) begin
                  if (cell_mv[i] > {3'b0, target_in}) bleed_in[i] = 1'b1;
                  else if (cell_mv[i] < {3'b0, lo_mv}) bleed_in[i] = 1'b0;
               end
            end
         end
         PH_DONE: begin
            off      = 1'b1;
            bleed_in = 6'd0;
            fan_in   = 1'b0;
         end
      endcase
      out_in.drive_cmd        = down ? DRV_DOWN : (up ? DRV_UP : DRV_HOLD);
      out_in.overcurrent_trip = {1'b0, cur} > ({3'b0, limit_in} + {7'b0, OC_MARGIN_MA});
      out_in.charger_off      = off;
      out_in.balance_mask     = bleed_in;
      out_in.phase            = phase_in;
      out_in.cooling_on       = fan_in;
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_PRE;
         count_ff   <= '0;
         target_ff  <= '0;
         limit_ff   <= '0;
         div10_ff   <= '0;
         div5_ff    <= '0;
         bleed_ff   <= '0;
         fan_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (step) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            target_ff <= target_in;
            limit_ff  <= limit_in;
            div10_ff  <= div10_in;
            div5_ff   <= div5_in;
            bleed_ff  <= bleed_in;
            fan_ff    <= fan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_ff <= req.payload;
      if (step) out_ff <= out_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

   // ---- checks ----
   `LCCC_ASSERT_NOW(a_off_means_done, clock, reset,
      out_vld_ff && out_ff.charger_off,
      out_ff.phase == PH_DONE && out_ff.balance_mask == 6'd0 && !out_ff.cooling_on,
      "charger off without done phase, clear bleeds and fan off")
   `LCCC_ASSERT_NEXT(a_item_moves, clock, reset,
      in_vld_ff && !out_vld_ff,
      out_vld_ff,
      "item held in input register while result register empty")
   `LCCC_ASSERT_NEXT(a_start_fan, clock, reset,
      step && in_ff.start_req,
      fan_ff && phase_ff != PH_DONE,
      "start tick did not leave fan on and charge running")
   `LCCC_ASSERT_NEXT(a_phase_order, clock, reset,
      step && !in_ff.start_req,
      phase_ff == $past(phase_ff) || phase_ff == phase_type'($past(phase_ff) + 2'd1),
      "phase skipped or went backward")

endmodule

`default_nettype wire

// ===== src/lithium_cell_charge_controller_top.sv =====
// Top level of the lithium cell CC/CV charge controller with balancing.
// Depends on lccc_pkg, lccc_if, lccc_csr and lccc_core.
//
//   channel   direction  handshake          payload
//   req_ch    in         valid/ready        start_req, current, six cell voltages
//   rsp_ch    out        valid/ready        drive_cmd, trip, off, mask, phase, fan
//   csr_*     in         csr_we only        csr_idx selects register, csr_wdata
//
// One item per cycle sustained while the result channel is ready; each item is
// held in the input register and its result is then written to the result register.
// A single evaluation stage sits between those two registers.
// A stalled result holds; the input register still takes one item meanwhile.
// Synchronous reset clears the charge state and loads register defaults;
// no clearing pass is needed.
`default_nettype none

module lithium_cell_charge_controller_top
   import lccc_pkg::*;
#(
   parameter int CELLS = CELLS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lccc_req_if.sink         req_ch,
   lccc_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_idx,
   input  wire logic [15:0] csr_wdata
);

   cfg_type cfg;

   lccc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lccc_core #(
      .CELLS (CELLS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/charge_check_pkg.sv =====
// Tick-by-tick prediction and output checking for the charge controller.
// Depends on lccc_pkg for the request, response, register and phase types.
package charge_check_pkg;
   import lccc_pkg::*;

   localparam logic [1:0] CHEM_LIPO   = 2'd0;
   localparam logic [1:0] CHEM_LIION  = 2'd1;
   localparam logic [1:0] CHEM_LIFE   = 2'd2;
   localparam logic [1:0] CHEM_LIHV   = 2'd3;
   localparam logic [1:0] MODE_CHARGE = 2'd1;

   localparam int unsigned STORAGE_CUT_DIV = 11;
   localparam int unsigned PRECHARGE_MV [4] = '{3200, 2500, 2500, 3300};

   function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   class charge_tracker;
      bit [1:0]  chem_type;
      bit [1:0]  charge_mode;
      bit [13:0] set_current_ma;
      bit [2:0]  cell_count;
      bit [12:0] target_mv;
      bit [9:0]  balance_hyst_mv;
      bit [9:0]  current_hyst_ma;
      bit [15:0] stable_ticks;

      phase_type phase;
      bit [15:0] stable_count;
      bit [12:0] cell_target;
      bit [13:0] drive_limit;
      bit [5:0]  bleed_mask;
      bit        fan_on;

      rsp_type   expected_outputs[$];
      int        failures;
      int        ticks_checked;

      function new();
         chem_type       = CHEM_LIPO;
         charge_mode     = MODE_BALANCE;
         set_current_ma  = '0;
         cell_count      = '0;
         target_mv       = RST_TARGET_MV;
         balance_hyst_mv = RST_BHYST_MV;
         current_hyst_ma = RST_CHYST_MA;
         stable_ticks    = RST_STABLE;
         phase           = PH_PRE;
         stable_count    = '0;
         cell_target     = '0;
         drive_limit     = '0;
         bleed_mask      = '0;
         fan_on          = 1'b0;
         failures        = 0;
         ticks_checked   = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [15:0] v);
         case (idx)
            CSR_CHEM_TYPE:    chem_type       = v[1:0];
            CSR_CHARGE_MODE:  charge_mode     = v[1:0];
            CSR_SET_CURRENT:  set_current_ma  = v[13:0];
            CSR_CELL_COUNT:   cell_count      = v[2:0];
            CSR_TARGET:       target_mv       = v[12:0];
            CSR_BALANCE_HYST: balance_hyst_mv = v[9:0];
            CSR_CURRENT_HYST: current_hyst_ma = v[9:0];
            CSR_STABLE_TICKS: stable_ticks    = v;
         endcase
      endfunction

      // one accepted item = one control tick = one expected output
      function void note_tick(req_type t);
         int unsigned mv [6];
         int unsigned cur, vmin, vmax, n, pre, endc, lo, tgt, lim;
         bit          up, down, off;
         rsp_type     r;
         mv[0] = t.cell1_mv;
         mv[1] = t.cell2_mv;
         mv[2] = t.cell3_mv;
         mv[3] = t.cell4_mv;
         mv[4] = t.cell5_mv;
         mv[5] = t.cell6_mv;
         cur  = t.charge_current_ma;
         up   = 1'b0;
         down = 1'b0;
         off  = 1'b0;
         vmin = 16'hFFFF;
         vmax = 0;

         if (t.start_req) begin
            tgt = target_mv;
            if (charge_mode == MODE_STORAGE) tgt = tgt - tgt / STORAGE_CUT_DIV;
            lim = (set_current_ma > MAX_CURRENT_MA) ? MAX_CURRENT_MA : set_current_ma;
            if (lim < current_hyst_ma) lim = current_hyst_ma;
            cell_target  = tgt[12:0];
            drive_limit  = lim[13:0];
            phase        = PH_PRE;
            stable_count = '0;
            fan_on       = 1'b1;
         end

         r.overcurrent_trip = (cur > drive_limit) && (cur - drive_limit > OC_MARGIN_MA);

         n = (cell_count > CELLS_DEF) ? CELLS_DEF : cell_count;
         for (int i = 0; i < n; i++) begin
            if (mv[i] > vmax) vmax = mv[i];
            if (mv[i] < vmin) vmin = mv[i];
         end

         if (cur > drive_limit) down = 1'b1;
         if (phase == PH_BAL) begin
            if (vmax > cell_target + balance_hyst_mv) down = 1'b1;
         end else if (vmax > cell_target) begin
            down = 1'b1;
         end

         case (phase)
            PH_PRE: begin
               if (vmin < PRECHARGE_MV[chem_type]) begin
                  pre = drive_limit / 10;
                  if (pre < current_hyst_ma) pre = current_hyst_ma;
                  if (cur > pre) down = 1'b1;
                  else if (cur < floor_sub(pre, current_hyst_ma)) up = 1'b1;
               end else begin
                  phase = PH_CCCV;
               end
            end
            PH_CCCV: begin
               endc = (charge_mode == MODE_FAST) ? drive_limit / 5 : drive_limit / 10;
               if (vmin < floor_sub(cell_target, balance_hyst_mv) ||
                   cur < floor_sub(drive_limit, current_hyst_ma))
                  up = 1'b1;
               if (cur < endc) begin
                  // counter wraps at 16 bits if the limit was lowered under it
                  if (stable_count != stable_ticks) stable_count = stable_count + 1'b1;
                  else phase = PH_BAL;
               end else begin
                  stable_count = '0;
               end
            end
            PH_BAL: begin
               lo = floor_sub(cell_target, balance_hyst_mv);
               if (charge_mode != MODE_BALANCE || vmin > lo) begin
                  phase = PH_DONE;
               end else begin
                  // all cells take part, whatever the cell count
                  for (int i = 0; i < 6; i++) begin
                     if (mv[i] > cell_target) bleed_mask[i] = 1'b1;
                     else if (mv[i] < lo) bleed_mask[i] = 1'b0;
                  end
               end
            end
            default: begin
               off        = 1'b1;
               bleed_mask = '0;
               fan_on     = 1'b0;
            end
         endcase

         r.drive_cmd    = down ? DRV_DOWN : (up ? DRV_UP : DRV_HOLD);
         r.charger_off  = off;
         r.balance_mask = bleed_mask;
         r.phase        = phase;
         r.cooling_on   = fan_on;
         expected_outputs.push_back(r);
      endfunction

      function int field_diff(string name, logic [15:0] want, logic [15:0] got);
         if (got === want) return 0;
         $display("%0t: output %0d %s expected %0d, got %0d",
                  $time, ticks_checked, name, want, got);
         return 1;
      endfunction

      function void check_output(rsp_type got);
         rsp_type want;
         if (expected_outputs.size() == 0) begin
            $display("%0t: output with no tick pending, expected none, got %h", $time, got);
            failures++;
            return;
         end
         want = expected_outputs.pop_front();
         failures += field_diff("drive_cmd", want.drive_cmd, got.drive_cmd);
         failures += field_diff("overcurrent_trip", want.overcurrent_trip,
                                got.overcurrent_trip);
         failures += field_diff("charger_off", want.charger_off, got.charger_off);
         failures += field_diff("balance_mask", want.balance_mask, got.balance_mask);
         failures += field_diff("phase", want.phase, got.phase);
         failures += field_diff("cooling_on", want.cooling_on, got.cooling_on);
         ticks_checked++;
      endfunction
   endclass
endpackage

// ===== tb/tb.sv =====
// Top testbench for lithium_cell_charge_controller_top: directed and random ticks.
// Depends on lccc_pkg, lccc_if, the RTL and charge_check_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lccc_pkg::*;
   import charge_check_pkg::*;

   typedef enum {MV_WILD, MV_PRECHARGE, MV_NEAR_TARGET} mv_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_idx;
   logic [15:0] csr_wdata;
   logic [15:0] reg_plan [8];
   bit          quiet;

   charge_tracker tracker;

   lccc_req_if req_ch ();
   lccc_rsp_if rsp_ch ();

   lithium_cell_charge_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) tracker.check_output(rsp_ch.payload);
   end

   function automatic req_type tick_of(bit s, int unsigned cur, int unsigned mv);
      req_type t;
      t.start_req         = s;
      t.charge_current_ma = cur[15:0];
      t.cell1_mv          = mv[15:0];
      t.cell2_mv          = mv[15:0];
      t.cell3_mv          = mv[15:0];
      t.cell4_mv          = mv[15:0];
      t.cell5_mv          = mv[15:0];
      t.cell6_mv          = mv[15:0];
      return t;
   endfunction

   function automatic logic [15:0] near_mv(int unsigned center, int unsigned spread);
      int v;
      v = int'(center) + int'($urandom_range(2 * spread)) - int'(spread);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   function automatic logic [15:0] cell_mv(mv_style_type style);
      case (style)
         MV_WILD:      return 16'($urandom_range(65535));
         MV_PRECHARGE: return near_mv(2900, 600);
         default:      return near_mv(tracker.cell_target, tracker.balance_hyst_mv + 20);
      endcase
   endfunction

   // current and cell levels follow the phase the tick will land in
   function automatic req_type random_tick(bit start);
      req_type      t;
      mv_style_type style;
      phase_type    ph;
      int unsigned  lim, pick, cur;
      ph   = start ? PH_PRE : tracker.phase;
      lim  = tracker.drive_limit;
      pick = $urandom_range(99);
      if (pick < 8) style = MV_WILD;
      else if (ph == PH_PRE && pick < 50) style = MV_PRECHARGE;
      else style = MV_NEAR_TARGET;
      pick = $urandom_range(99);
      if (pick < 8) cur = $urandom_range(65535);
      else if (pick < 16) cur = lim + 400 + $urandom_range(200);
      else if (ph == PH_CCCV && pick < 80) cur = $urandom_range(lim / 10);
      else if (ph == PH_PRE) cur = $urandom_range(lim / 10 + tracker.current_hyst_ma + 50);
      else cur = $urandom_range(lim + 200);
      t = tick_of(start, cur, 0);
      t.cell1_mv = cell_mv(style);
      t.cell2_mv = cell_mv(style);
      t.cell3_mv = cell_mv(style);
      t.cell4_mv = cell_mv(style);
      t.cell5_mv = cell_mv(style);
      t.cell6_mv = cell_mv(style);
      return t;
   endfunction

   task automatic send_tick(req_type item);
      while (!quiet && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.note_tick(item);
   endtask

   task automatic drain_outputs();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_outputs.size() != 0);
   endtask

   task automatic write_plan();
      csr_idx_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = csr_idx_type'(i);
         csr_we    <= 1'b1;
         csr_idx   <= idx;
         csr_wdata <= reg_plan[idx];
         @(posedge clock);
         tracker.set_reg(idx, reg_plan[idx]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic set_plan(logic [1:0] chem, logic [1:0] mode, int unsigned cur_ma,
                           int unsigned cells, int unsigned tgt_mv, int unsigned bhyst,
                           int unsigned chyst, int unsigned stable);
      reg_plan[CSR_CHEM_TYPE]    = 16'(chem);
      reg_plan[CSR_CHARGE_MODE]  = 16'(mode);
      reg_plan[CSR_SET_CURRENT]  = 16'(cur_ma);
      reg_plan[CSR_CELL_COUNT]   = 16'(cells);
      reg_plan[CSR_TARGET]       = 16'(tgt_mv);
      reg_plan[CSR_BALANCE_HYST] = 16'(bhyst);
      reg_plan[CSR_CURRENT_HYST] = 16'(chyst);
      reg_plan[CSR_STABLE_TICKS] = 16'(stable);
   endtask

   task automatic pick_plan();
      set_plan(2'($urandom_range(3)),
               $urandom_range(1) ? MODE_BALANCE : 2'($urandom_range(3)),
               ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(300, 10000),
               ($urandom_range(3) == 0) ? $urandom_range(7) : CELLS_DEF,
               ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(3400, 4400),
               ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(2, 60),
               ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(10, 200),
               ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(12));
   endtask

   initial begin
      req_type     t;
      int unsigned n;
      bit          start;
      tracker        = new();
      quiet          = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_idx        = CSR_CHEM_TYPE;
      csr_wdata      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // no start yet: zero target and limit
      send_tick(tick_of(0, 0, 0));
      send_tick(tick_of(0, 16'hFFFF, 16'hFFFF));
      drain_outputs();

      // clamped set current, cell count above six, immediate end of charge
      set_plan(CHEM_LIHV, MODE_BALANCE, 16383, 7, 4200, 20, 100, 0);
      write_plan();
      send_tick(tick_of(1, 0, 3000));
      send_tick(tick_of(0, 2000, 3000));
      send_tick(tick_of(0, 950, 3000));
      send_tick(tick_of(0, 10501, 3000));
      send_tick(tick_of(0, 500, 4100));
      send_tick(tick_of(0, 500, 4100));
      t = tick_of(0, 500, 4190);
      t.cell1_mv = 4300;
      t.cell2_mv = 4150;
      send_tick(t);
      send_tick(tick_of(1, 500, 3000));  // restart keeps the bleeds
      send_tick(tick_of(0, 500, 4190));
      send_tick(tick_of(0, 500, 4190));
      send_tick(tick_of(0, 500, 4190));
      send_tick(tick_of(0, 500, 4190));
      drain_outputs();

      // storage cut on the top target, zero limit, no cells counted
      set_plan(CHEM_LIION, MODE_STORAGE, 0, 0, 8191, 1023, 0, 65535);
      write_plan();
      send_tick(tick_of(1, 16'hFFFF, 0));
      send_tick(tick_of(0, 0, 16'hFFFF));
      drain_outputs();

      set_plan(CHEM_LIFE, MODE_FAST, 10000, 6, 0, 0, 1, 2);
      write_plan();
      send_tick(tick_of(1, 0, 2400));
      repeat (5) send_tick(tick_of(0, 100, 2600));
      drain_outputs();

      set_plan(CHEM_LIPO, MODE_CHARGE, 2000, 6, 4200, 10, 50, 5);
      write_plan();
      send_tick(tick_of(1, 300, 3100));
      send_tick(tick_of(0, 300, 3900));
      drain_outputs();

      for (int p = 0; p < 14; p++) begin
         pick_plan();
         write_plan();
         quiet = (p == 5 || p == 6);
         n = $urandom_range(80, 130);
         for (int k = 0; k < n; k++) begin
            start = (k == 0 && $urandom_range(3) != 0) || ($urandom_range(99) < 2) ||
                    (tracker.phase == PH_DONE && $urandom_range(9) == 0);
            send_tick(random_tick(start));
         end
         drain_outputs();
      end
      quiet = 1'b0;

      // lower the debounce to a running count: the next low-current tick ends CC/CV
      set_plan(CHEM_LIPO, MODE_CHARGE, 1000, 0, 4200, 10, 50, 3);
      write_plan();
      send_tick(tick_of(1, 0, $urandom_range(65535)));
      send_tick(tick_of(0, 0, $urandom_range(65535)));
      send_tick(tick_of(0, 0, $urandom_range(65535)));
      drain_outputs();
      reg_plan[CSR_STABLE_TICKS] = 16'd2;
      write_plan();
      while (tracker.phase == PH_CCCV)
         send_tick(tick_of(0, $urandom_range(99), $urandom_range(65535)));
      send_tick(tick_of(0, 0, 4000));
      send_tick(tick_of(0, 0, 4000));
      drain_outputs();

      repeat (5) @(posedge clock);
      if (tracker.failures == 0 && tracker.expected_outputs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
